// ----- design/mi3_pkg.sv -----
// Shared types and constants of the 3x3 adjugate matrix inverter.
`timescale 1ns / 1ps
`default_nettype none
package mi3_pkg;

  localparam int EW     = 32;  // element width, Q16.16
  localparam int COF_W  = 65;  // exact cofactor width
  localparam int MAG_W  = 64;  // cofactor magnitude width
  localparam int PP_W   = 65;  // determinant partial product width
  localparam int DET_W  = 97;  // exact determinant width
  localparam int DEN_W  = 96;  // determinant magnitude width
  localparam int QB     = 32;  // quotient bits
  localparam int NLANE  = 9;
  localparam int FRONT  = 7;   // stages ahead of the divider
  localparam int LAT    = FRONT + QB + 1;

  typedef struct packed {
    logic signed [EW-1:0] in_c0_r0;
    logic signed [EW-1:0] in_c0_r1;
    logic signed [EW-1:0] in_c0_r2;
    logic signed [EW-1:0] in_c1_r0;
    logic signed [EW-1:0] in_c1_r1;
    logic signed [EW-1:0] in_c1_r2;
    logic signed [EW-1:0] in_c2_r0;
    logic signed [EW-1:0] in_c2_r1;
    logic signed [EW-1:0] in_c2_r2;
  } mi3_in_t;

  typedef struct packed {
    logic signed [EW-1:0] out_c0_r0;
    logic signed [EW-1:0] out_c0_r1;
    logic signed [EW-1:0] out_c0_r2;
    logic signed [EW-1:0] out_c1_r0;
    logic signed [EW-1:0] out_c1_r1;
    logic signed [EW-1:0] out_c1_r2;
    logic signed [EW-1:0] out_c2_r0;
    logic signed [EW-1:0] out_c2_r1;
    logic signed [EW-1:0] out_c2_r2;
    logic                 singular;
    logic                 overflow;
  } mi3_out_t;

  typedef struct packed {
    logic [NLANE-1:0] neg;
    logic [NLANE-1:0] sat;
    logic             singular;
  } mi3_tag_t;

endpackage
`default_nettype wire

// ----- design/mi3_divider.sv -----
// Nine-lane restoring divider pipeline, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module mi3_divider (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic [mi3_pkg::DEN_W-1:0] den,
  input  wire logic [mi3_pkg::DEN_W-1:0] rem_in [mi3_pkg::NLANE],
  input  wire mi3_pkg::mi3_tag_t         tag_in,
  output logic                           out_valid,
  output logic [mi3_pkg::QB-1:0]         quot [mi3_pkg::NLANE],
  output mi3_pkg::mi3_tag_t              tag_out
);
  import mi3_pkg::*;

  logic [DEN_W-1:0] rem [QB+1][NLANE];
  logic [QB-1:0]    quo [QB+1][NLANE];
  logic [DEN_W-1:0] den_s [QB+1];
  mi3_tag_t         tag_s [QB+1];
  logic             vld [QB+1];

  assign den_s[0] = den;
  assign tag_s[0] = tag_in;
  assign vld[0]   = in_valid;

  for (genvar l = 0; l < NLANE; l++) begin : g_in
    assign rem[0][l] = rem_in[l];
    assign quo[0][l] = '0;
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      den_s[k+1] <= den_s[k];
      tag_s[k+1] <= tag_s[k];
    end

    for (genvar l = 0; l < NLANE; l++) begin : g_lane
      logic [DEN_W:0] shifted;
      logic [DEN_W:0] diff;
      logic           ge;

      assign shifted = {rem[k][l], 1'b0};
      assign ge      = shifted >= {1'b0, den_s[k]};
      assign diff    = shifted - {1'b0, den_s[k]};

      always_ff @(posedge clk) begin
        rem[k+1][l] <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        quo[k+1][l] <= {quo[k][l][QB-2:0], ge};
      end
    end
  end

  assign out_valid = vld[QB];
  assign tag_out   = tag_s[QB];
  for (genvar l = 0; l < NLANE; l++) begin : g_out
    assign quot[l] = quo[QB][l];
  end

endmodule
`default_nettype wire

// ----- design/matrix3_inverse_adjugate.sv -----
// Top level of the pipelined 3x3 matrix inverter in signed Q16.16.
//
// A matrix beat is taken on operand at each rising edge with start high and
// busy low. busy is always low, so a new matrix may enter in every cycle.
// The inverse leaves on result, valid for one cycle while done is high; one
// result per matrix, in order. Throughput is one matrix per cycle. The
// pipeline holds seven stages of cofactor and determinant arithmetic
// (products, cofactors, partial products, terms, sum, magnitude, range
// check), one stage per quotient bit in the 32-stage restoring divider,
// and one output stage.
// A zero determinant gives an all-zero matrix with singular set. A quotient
// outside Q16.16 saturates and sets overflow.
// Synchronous reset clears all valid bits; matrices in flight are dropped.
// The receiver cannot stall, so every result must be taken when done is high.
`timescale 1ns / 1ps
`default_nettype none
module matrix3_inverse_adjugate (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire mi3_pkg::mi3_in_t  operand,
  output logic                   done,
  output mi3_pkg::mi3_out_t      result
);
  import mi3_pkg::*;

  logic signed [EW-1:0]    el [3][3];
  logic signed [2*EW-1:0]  p1 [3][3];
  logic signed [2*EW-1:0]  q1 [3][3];
  logic signed [COF_W-1:0] cof2 [3][3];
  logic signed [EW-1:0]    e1 [3];
  logic signed [EW-1:0]    e2 [3];
  logic signed [PP_W-1:0]  pl3 [3];
  logic signed [PP_W-1:0]  ph3 [3];
  logic signed [DET_W-1:0] t4 [3];
  logic signed [DET_W-1:0] det5;
  logic [MAG_W-1:0]        mag3 [3][3];
  logic [MAG_W-1:0]        mag4 [3][3];
  logic [MAG_W-1:0]        mag5 [3][3];
  logic [MAG_W-1:0]        mag6 [3][3];
  logic                    cs3 [3][3];
  logic                    cs4 [3][3];
  logic                    cs5 [3][3];
  logic                    cs6 [3][3];
  logic [DEN_W-1:0]        dmag6;
  logic                    dneg6;
  logic                    dzero6;
  logic [DEN_W-1:0]        den7;
  logic [DEN_W-1:0]        rem7 [NLANE];
  mi3_tag_t                tag7;
  logic [FRONT-1:0]        vld;
  logic                    div_valid;
  logic [QB-1:0]           quot [NLANE];
  mi3_tag_t                div_tag;
  logic [EW-1:0]           lane_val [NLANE];
  logic [NLANE-1:0]        lane_sat;
  mi3_out_t                result_next;

  assign busy = 1'b0;

  assign el[0][0] = operand.in_c0_r0;
  assign el[0][1] = operand.in_c0_r1;
  assign el[0][2] = operand.in_c0_r2;
  assign el[1][0] = operand.in_c1_r0;
  assign el[1][1] = operand.in_c1_r1;
  assign el[1][2] = operand.in_c1_r2;
  assign el[2][0] = operand.in_c2_r0;
  assign el[2][1] = operand.in_c2_r1;
  assign el[2][2] = operand.in_c2_r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FRONT-2:0], start & ~busy};
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_col
    for (genvar r = 0; r < 3; r++) begin : g_row
      localparam int C1 = (c == 0) ? 1 : 0;
      localparam int C2 = (c == 2) ? 1 : 2;
      localparam int R1 = (r == 0) ? 1 : 0;
      localparam int R2 = (r == 2) ? 1 : 2;
      localparam bit ODD = ((c + r) % 2) != 0;

      always_ff @(posedge clk) begin
        p1[c][r]   <= el[C1][R1] * el[C2][R2];
        q1[c][r]   <= el[C2][R1] * el[C1][R2];
        cof2[c][r] <= ODD ? (COF_W'(q1[c][r]) - COF_W'(p1[c][r]))
                          : (COF_W'(p1[c][r]) - COF_W'(q1[c][r]));
        cs3[c][r]  <= cof2[c][r][COF_W-1];
        mag3[c][r] <= cof2[c][r][COF_W-1] ? MAG_W'(-cof2[c][r]) : MAG_W'(cof2[c][r]);
        cs4[c][r]  <= cs3[c][r];
        mag4[c][r] <= mag3[c][r];
        cs5[c][r]  <= cs4[c][r];
        mag5[c][r] <= mag4[c][r];
        cs6[c][r]  <= cs5[c][r];
        mag6[c][r] <= mag5[c][r];
      end
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_det
    always_ff @(posedge clk) begin
      e1[r]  <= el[0][r];
      e2[r]  <= e1[r];
      pl3[r] <= e2[r] * $signed({1'b0, cof2[0][r][EW-1:0]});
      ph3[r] <= e2[r] * $signed(cof2[0][r][COF_W-1:EW]);
      t4[r]  <= (DET_W'(ph3[r]) <<< EW) + DET_W'(pl3[r]);
    end
  end

  always_ff @(posedge clk) begin
    det5   <= t4[0] + t4[1] + t4[2];
    dneg6  <= det5[DET_W-1];
    dzero6 <= det5 == '0;
    dmag6  <= det5[DET_W-1] ? DEN_W'(-det5) : DEN_W'(det5);
    den7   <= dmag6;
    tag7.singular <= dzero6;
  end

  // Lane c*3+r divides the cofactor of the mirrored position (r, c).
  for (genvar c = 0; c < 3; c++) begin : g_lc
    for (genvar r = 0; r < 3; r++) begin : g_lr
      localparam int L = c * 3 + r;
      logic sat_now;

      assign sat_now = {{(DEN_W-MAG_W){1'b0}}, mag6[r][c]} >= dmag6;

      always_ff @(posedge clk) begin
        tag7.sat[L] <= sat_now;
        tag7.neg[L] <= cs6[r][c] ^ dneg6;
        rem7[L]     <= sat_now ? '0 : {{(DEN_W-MAG_W){1'b0}}, mag6[r][c]};
      end
    end
  end

  mi3_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[FRONT-1]),
    .den       (den7),
    .rem_in    (rem7),
    .tag_in    (tag7),
    .out_valid (div_valid),
    .quot      (quot),
    .tag_out   (div_tag)
  );

  always_comb begin
    logic [EW-1:0] limit;
    logic [EW-1:0] mag;
    logic          sat;
    for (int i = 0; i < NLANE; i++) begin
      limit = div_tag.neg[i] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
      sat   = div_tag.sat[i] || (quot[i] > limit);
      mag   = sat ? limit : quot[i];
      lane_sat[i] = sat && !div_tag.singular;
      if (div_tag.singular) begin
        lane_val[i] = '0;
      end else begin
        lane_val[i] = div_tag.neg[i] ? (~mag + 1'b1) : mag;
      end
    end
    result_next.out_c0_r0 = lane_val[0];
    result_next.out_c0_r1 = lane_val[1];
    result_next.out_c0_r2 = lane_val[2];
    result_next.out_c1_r0 = lane_val[3];
    result_next.out_c1_r1 = lane_val[4];
    result_next.out_c1_r2 = lane_val[5];
    result_next.out_c2_r0 = lane_val[6];
    result_next.out_c2_r1 = lane_val[7];
    result_next.out_c2_r2 = lane_val[8];
    result_next.singular  = div_tag.singular;
    result_next.overflow  = |lane_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result beat without a matching matrix beat");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    done && result.singular |-> !result.overflow)
    else $error("singular and overflow both set");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.singular |-> result.out_c0_r0 == '0 && result.out_c1_r1 == '0
                                && result.out_c2_r2 == '0)
    else $error("singular result is not all zero");

endmodule
`default_nettype wire
